[design/ptt_pkg.sv]
// ptt_pkg: shared types and constants of the periodic timer table.
// Used by ptt_alu and periodic_timer_table. No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STARTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
    logic              one_shot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_TICK = 3'b100
  } state_t;

endpackage

`default_nettype wire

[design/ptt_ram.sv]
// ptt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/ptt_alu.sv]
// ptt_alu: the shared 32-bit add and unsigned compare unit.
// Depends on ptt_pkg.
`default_nettype none

module ptt_alu
  import ptt_pkg::*;
(
  input  wire logic [TIME_W-1:0] a,
  input  wire logic [TIME_W-1:0] b,
  input  wire logic [TIME_W-1:0] c,
  output logic      [TIME_W-1:0] sum,
  output logic                   le
);

  // wrap-around add: start due time or periodic reload
  assign sum = a + b;

  // due check: a at or below c, unsigned
  assign le = (a <= c);

endmodule

`default_nettype wire

[design/periodic_timer_table.sv]
// periodic_timer_table: top level, sequencer over the slot memory and shared unit.
// Depends on ptt_pkg, ptt_ram and ptt_alu.
`default_nettype none

// A word is taken when start is high and busy is low; busy stays high until
// the sequencer has issued every result of that word. Results come at most
// one per cycle on strobe and cannot be held off. A start probes one slot per
// cycle from slot 0 upward and stops at the lowest free slot, or after the
// last slot when the table is full. A tick reads one slot per cycle from the
// slot memory (registered read), checks it in the following cycle, reloads a
// due periodic slot via the shared adder or frees a due one-shot slot, and
// then issues the done result. Each result appears on the ports in the cycle
// after the sequencer decides it, so the final strobe coincides with busy low.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 op,
  input  wire logic [31:0]          now_ms,
  input  wire logic [31:0]          interval_ms,
  input  wire logic                 run_once,
  output logic                      strobe,
  output logic      [1:0]           kind,
  output logic      [3:0]           slot,
  output logic                      freed,
  output logic                      last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t              state;
  logic [SLOTS-1:0]    valid;
  logic [IW-1:0]       rd_idx;
  logic                rd_on;
  logic                ev_vld;
  logic [IW-1:0]       ev_idx;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   ival_r;
  logic                once_r;

  logic                accept;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  logic [TIME_W-1:0]   alu_a;
  logic [TIME_W-1:0]   alu_b;
  logic [TIME_W-1:0]   alu_sum;
  logic                alu_le;
  logic                free_hit;
  logic                due_hit;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // slot memory: due time, period and one-shot flag
  ptt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // shared unit operands: start uses now+interval, tick uses due+period
  always_comb begin
    if (state == S_FIND) begin
      alu_a = now_r;
      alu_b = ival_r;
    end else begin
      alu_a = ram_rdata.due;
      alu_b = ram_rdata.period;
    end
  end

  ptt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (now_r),
    .sum (alu_sum),
    .le  (alu_le)
  );

  assign free_hit = (state == S_FIND) && !valid[rd_idx];
  assign due_hit  = (state == S_TICK) && ev_vld && valid[ev_idx] && alu_le;

  // memory write: new timer on start, reload of a periodic slot on tick
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = '{due: alu_sum, period: ival_r, one_shot: once_r};
    if (free_hit) begin
      ram_we = 1'b1;
    end else if (due_hit && !ram_rdata.one_shot) begin
      ram_we    = 1'b1;
      ram_waddr = ev_idx;
      ram_wdata = '{due: alu_sum, period: ram_rdata.period, one_shot: 1'b0};
    end
  end

  // sequencer, valid bits and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      rd_idx <= '0;
      rd_on  <= 1'b0;
      ev_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          rd_idx <= '0;
          if (accept) begin
            rd_on <= (op == OP_TICK);
            state <= (op == OP_TICK) ? S_TICK : S_FIND;
          end
        end
        S_FIND: begin
          if (free_hit) begin
            valid[rd_idx] <= 1'b1;
            strobe        <= 1'b1;
            state         <= S_IDLE;
          end else if (rd_idx == LAST_IDX) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_TICK: begin
          ev_vld <= rd_on;
          if (rd_on) begin
            if (rd_idx == LAST_IDX) begin
              rd_on <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (due_hit) begin
            strobe <= 1'b1;
            if (ram_rdata.one_shot) begin
              valid[ev_idx] <= 1'b0;
            end
          end
          if (!rd_on && !ev_vld) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input word capture and ev stage index
  always_ff @(posedge clk) begin
    ev_idx <= rd_idx;
    if (accept) begin
      now_r  <= now_ms;
      ival_r <= interval_ms;
      once_r <= run_once;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind  <= KIND_DONE;
    slot  <= '0;
    freed <= 1'b0;
    last  <= 1'b1;
    case (state)
      S_FIND: begin
        if (free_hit) begin
          kind <= KIND_STARTED;
          slot <= SLOT_W'(rd_idx);
        end else begin
          kind <= KIND_FULL;
        end
      end
      S_TICK: begin
        if (due_hit) begin
          kind  <= KIND_FIRED;
          slot  <= SLOT_W'(ev_idx);
          freed <= ram_rdata.one_shot;
          last  <= 1'b0;
        end
      end
      default: begin
        kind <= KIND_DONE;
      end
    endcase
  end

  // checks
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_FIRED |-> !last)
    else $error("fired result marked last");

  a_plain_results: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == KIND_FULL || kind == KIND_DONE) |-> slot == '0 && !freed)
    else $error("full or done result carries slot or freed");

  a_freed_fired: assert property (@(posedge clk) disable iff (rst)
    strobe && freed |-> kind == KIND_FIRED)
    else $error("freed set on a result that is not a firing");

  a_eval_in_tick: assert property (@(posedge clk) disable iff (rst)
    ev_vld |-> state == S_TICK)
    else $error("evaluation stage active outside a tick");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accepting a word");

endmodule

`default_nettype wire
